// ----- src/rpbc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpbc_pkg
// Shared constants, types and helpers for the box-center point rotator.
// ----------------------------------------------------------------------------
package rpbc_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_W    = 32;
    localparam int NUM_COORD  = 9;
    localparam int MEM_DEPTH  = MAX_POINTS * NUM_COORD;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int MAT_W      = 32;
    localparam int OPA_W      = 34;
    localparam int OPB_W      = 18;
    localparam int PROD_W     = OPA_W + OPB_W;
    localparam int ACC_W      = 64;
    localparam int MLO_W      = 17;
    localparam int MAT_FRAC   = 20;
    localparam int TDATA_W    = NUM_COORD * COORD_W;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_COS_YAW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_YAW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_PITCH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_PITCH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_ROLL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_ROLL  = 3'd5;

    localparam logic signed [CFG_W-1:0] Q14_ONE = 16'sd16384;

    // factor selects for matrix terms
    typedef logic [2:0] fsel_t;
    localparam fsel_t SEL_CY   = 3'd0;
    localparam fsel_t SEL_SY   = 3'd1;
    localparam fsel_t SEL_CP   = 3'd2;
    localparam fsel_t SEL_SP   = 3'd3;
    localparam fsel_t SEL_CR   = 3'd4;
    localparam fsel_t SEL_SR   = 3'd5;
    localparam fsel_t SEL_ONE  = 3'd6;
    localparam fsel_t SEL_ZERO = 3'd7;

    typedef struct packed {
        fsel_t a;
        fsel_t b;
        fsel_t c;
        logic  neg;
    } mterm_t;

    localparam mterm_t TERM_NONE = '{a: SEL_ZERO, b: SEL_ZERO, c: SEL_ZERO, neg: 1'b0};

    // R = Ry * Rx * Rz, each entry a sum of at most two triple products
    function automatic mterm_t mat_term(input logic [3:0] k, input logic t);
        mterm_t r;
        r = TERM_NONE;
        case (k)
            4'd0: r = t ? '{SEL_SY, SEL_SP, SEL_SR, 1'b0} : '{SEL_CY, SEL_ONE, SEL_CR, 1'b0};
            4'd1: r = t ? '{SEL_SY, SEL_SP, SEL_CR, 1'b0} : '{SEL_CY, SEL_ONE, SEL_SR, 1'b1};
            4'd2: r = t ? TERM_NONE : '{SEL_SY, SEL_CP, SEL_ONE, 1'b0};
            4'd3: r = t ? TERM_NONE : '{SEL_CP, SEL_SR, SEL_ONE, 1'b0};
            4'd4: r = t ? TERM_NONE : '{SEL_CP, SEL_CR, SEL_ONE, 1'b0};
            4'd5: r = t ? TERM_NONE : '{SEL_SP, SEL_ONE, SEL_ONE, 1'b1};
            4'd6: r = t ? '{SEL_CY, SEL_SP, SEL_SR, 1'b0} : '{SEL_SY, SEL_ONE, SEL_CR, 1'b1};
            4'd7: r = t ? '{SEL_CY, SEL_SP, SEL_CR, 1'b0} : '{SEL_SY, SEL_ONE, SEL_SR, 1'b0};
            4'd8: r = t ? TERM_NONE : '{SEL_CY, SEL_CP, SEL_ONE, 1'b0};
            default: r = TERM_NONE;
        endcase
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = (ACC_W'(1) <<< (COORD_W - 1)) - ACC_W'(1);
        lo = -hi - ACC_W'(1);
        if (v > hi) begin
            return hi[COORD_W-1:0];
        end else if (v < lo) begin
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

// ----- src/rotate_points_about_box_center.sv -----
// ----------------------------------------------------------------------------
// rotate_points_about_box_center
// Collects a set of control points, then rotates them about their box center.
// ----------------------------------------------------------------------------
// Points arrive one per request; each is written to the point store one
// coordinate at a time while the anchor bounding box is updated.
// Points past 64 are dropped. The request with s_tlast closes the set: the
// rotation matrix is built, then each stored point is loaded, computed and
// emitted, all products going through one shared 34x18 multiplier (6
// products per output coordinate, 9 coordinates). Each result is held until
// m_tready takes it. s_tready is low while a point is being written, and
// from the accept of a closing request until its set has been drained.
module rotate_points_about_box_center
    import rpbc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // anchor_x, anchor_y, anchor_z, back_x, back_y, back_z, fore_x, fore_y, fore_z
    input  logic [TDATA_W-1:0]    s_tdata,
    // back_used, fore_used
    input  logic [1:0]            s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_anchor_x/y/z, out_back_x/y/z, out_fore_x/y/z
    output logic [TDATA_W-1:0]    m_tdata,
    // out_back_used, out_fore_used
    output logic [1:0]            m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_STORE = 6'b000010,
        ST_MAT   = 6'b000100,
        ST_LOAD  = 6'b001000,
        ST_CALC  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic signed [CFG_W-1:0] cy_reg, sy_reg, cp_reg, sp_reg, cr_reg, sr_reg;

    logic signed [COORD_W-1:0] in_reg [NUM_COORD];
    logic [1:0]                in_flag_reg;
    logic                      in_fin_reg;

    logic [COORD_W-1:0] coord_mem [MEM_DEPTH];
    logic [1:0]         flag_mem  [MAX_POINTS];
    logic [COORD_W-1:0] mem_rd_reg;
    logic [1:0]         flag_rd_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [ADDR_W-1:0]  wr_base, rd_base;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [3:0]       step_reg, step_next;
    logic [3:0]       ent_reg, ent_next;
    logic [1:0]       grp_reg, grp_next;
    logic [1:0]       row_reg, row_next;

    logic signed [COORD_W-1:0] box_min_reg [3];
    logic signed [COORD_W-1:0] box_max_reg [3];
    logic signed [MAT_W-1:0]   mat_reg [NUM_COORD];
    logic signed [COORD_W-1:0] pt_reg  [NUM_COORD];
    logic [1:0]                pt_flag_reg;
    logic signed [COORD_W-1:0] res_reg [NUM_COORD];

    logic signed [OPA_W-1:0]  mul_a;
    logic signed [OPB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg, prod_vld_next;
    logic                     prod_sh_reg, prod_sh_next;
    logic                     prod_neg_reg, prod_neg_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic                      in_acc, out_acc;
    logic                      is_last;
    logic [1:0]                axis, bsel, jj;
    logic signed [COORD_W-1:0] in_cur;
    logic signed [OPA_W-1:0]   s_sel;
    logic signed [COORD_W-1:0] pt_sel;
    logic signed [MAT_W-1:0]   m_sel;
    logic signed [ACC_W-1:0]   prod_ext, fin_val;
    logic                      term_t;
    mterm_t                    term;

    function automatic logic [3:0] idx3(input logic [1:0] hi, input logic [1:0] lo);
        return 4'(hi) * 4'd3 + 4'(lo);
    endfunction

    function automatic logic signed [CFG_W-1:0] fval(
        input fsel_t s,
        input logic signed [CFG_W-1:0] cy, sy, cp, sp, cr, sr
    );
        logic signed [CFG_W-1:0] v;
        case (s)
            SEL_CY:  v = cy;
            SEL_SY:  v = sy;
            SEL_CP:  v = cp;
            SEL_SP:  v = sp;
            SEL_CR:  v = cr;
            SEL_SR:  v = sr;
            SEL_ONE: v = Q14_ONE;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign is_last  = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;
    assign m_tlast  = is_last;
    assign m_tuser  = pt_flag_reg;

    always_comb begin
        for (int k = 0; k < NUM_COORD; k++) begin
            m_tdata[k*COORD_W +: COORD_W] = res_reg[k];
        end
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cy_reg <= Q14_ONE;
            sy_reg <= '0;
            cp_reg <= Q14_ONE;
            sp_reg <= '0;
            cr_reg <= Q14_ONE;
            sr_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_COS_YAW:   cy_reg <= cfg_wdata;
                CFG_SIN_YAW:   sy_reg <= cfg_wdata;
                CFG_COS_PITCH: cp_reg <= cfg_wdata;
                CFG_SIN_PITCH: sp_reg <= cfg_wdata;
                CFG_COS_ROLL:  cr_reg <= cfg_wdata;
                CFG_SIN_ROLL:  sr_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // point store
    assign wr_base   = ADDR_W'(cnt_reg[IDX_W-1:0]) * ADDR_W'(NUM_COORD);
    assign rd_base   = ADDR_W'(idx_reg) * ADDR_W'(NUM_COORD);
    assign mem_we    = (state_reg == ST_STORE);
    assign mem_waddr = wr_base + ADDR_W'(step_reg);
    assign mem_raddr = rd_base + ADDR_W'((step_reg > 4'd8) ? 4'd8 : step_reg);
    assign in_cur    = in_reg[step_reg];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            coord_mem[mem_waddr] <= in_cur;
        end
        mem_rd_reg <= coord_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (mem_we && step_reg == 4'd0) begin
            flag_mem[cnt_reg[IDX_W-1:0]] <= in_flag_reg;
        end
        flag_rd_reg <= flag_mem[idx_reg];
    end

    // operand selection
    assign jj     = step_reg[2:1];
    assign axis   = step_reg[1:0];
    assign bsel   = (step_reg == 4'd7) ? row_reg : jj;
    assign s_sel  = OPA_W'(box_min_reg[bsel]) + OPA_W'(box_max_reg[bsel]);
    assign pt_sel = pt_reg[(step_reg == 4'd7) ? idx3(grp_reg, row_reg) : idx3(grp_reg, jj)];
    assign m_sel  = mat_reg[idx3(row_reg, jj)];
    assign term_t = (step_reg >= 4'd3);
    assign term   = mat_term(ent_reg, term_t);

    always_comb begin
        mul_a         = '0;
        mul_b         = '0;
        prod_vld_next = 1'b0;
        prod_sh_next  = 1'b0;
        prod_neg_next = 1'b0;
        if (state_reg == ST_MAT) begin
            if (step_reg == 4'd0 || step_reg == 4'd3) begin
                mul_a = OPA_W'(fval(term.a, cy_reg, sy_reg, cp_reg, sp_reg, cr_reg, sr_reg));
                mul_b = OPB_W'(fval(term.b, cy_reg, sy_reg, cp_reg, sp_reg, cr_reg, sr_reg));
            end else begin
                mul_a = prod_reg[OPA_W-1:0];
                mul_b = OPB_W'(fval(term.c, cy_reg, sy_reg, cp_reg, sp_reg, cr_reg, sr_reg));
            end
        end else if (state_reg == ST_CALC && step_reg < 4'd6) begin
            if (grp_reg == 2'd0) begin
                mul_a = (OPA_W'(pt_sel) <<< 1) - s_sel;
            end else begin
                mul_a = OPA_W'(pt_sel);
            end
            if (step_reg[0]) begin
                mul_b = OPB_W'($signed(m_sel[MAT_W-1:MLO_W]));
            end else begin
                mul_b = {1'b0, m_sel[MLO_W-1:0]};
            end
            prod_vld_next = 1'b1;
            prod_sh_next  = step_reg[0];
        end
        if (state_reg == ST_MAT) begin
            prod_neg_next = term.neg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // rounding of the finished sum (half added here)
    always_comb begin
        if (grp_reg == 2'd0) begin
            fin_val = (acc_reg + (ACC_W'(s_sel) <<< MAT_FRAC) + (ACC_W'(1) <<< MAT_FRAC))
                      >>> (MAT_FRAC + 1);
        end else begin
            fin_val = (acc_reg + (ACC_W'(1) <<< (MAT_FRAC - 1))) >>> MAT_FRAC;
        end
    end

    always_comb begin
        acc_next = acc_reg;
        case (state_reg)
            ST_MAT: begin
                if (step_reg == 4'd0) begin
                    acc_next = '0;
                end else if (step_reg == 4'd2 || step_reg == 4'd5) begin
                    acc_next = prod_neg_reg ? acc_reg - prod_ext : acc_reg + prod_ext;
                end
            end
            ST_CALC: begin
                if (step_reg == 4'd0) begin
                    acc_next = '0;
                end else if (prod_vld_reg) begin
                    acc_next = acc_reg + (prod_sh_reg ? (prod_ext <<< MLO_W) : prod_ext);
                end
            end
            default: acc_next = acc_reg;
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        ent_next   = ent_reg;
        grp_next   = grp_reg;
        row_next   = row_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    step_next = '0;
                    ent_next  = '0;
                    if (cnt_reg != CNT_W'(MAX_POINTS)) begin
                        state_next = ST_STORE;
                    end else if (s_tlast) begin
                        state_next = ST_MAT;
                    end
                end
            end
            ST_STORE: begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd8) begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    step_next  = '0;
                    ent_next   = '0;
                    state_next = in_fin_reg ? ST_MAT : ST_IDLE;
                end
            end
            ST_MAT: begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd6) begin
                    step_next = '0;
                    ent_next  = ent_reg + 4'd1;
                    if (ent_reg == 4'd8) begin
                        idx_next   = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd9) begin
                    step_next  = '0;
                    grp_next   = '0;
                    row_next   = '0;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd7) begin
                    step_next = '0;
                    if (row_reg == 2'd2) begin
                        row_next = '0;
                        grp_next = grp_reg + 2'd1;
                        if (grp_reg == 2'd2) begin
                            state_next = ST_OUT;
                        end
                    end else begin
                        row_next = row_reg + 2'd1;
                    end
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    step_next = '0;
                    if (is_last) begin
                        cnt_next   = '0;
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_LOAD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            step_reg     <= '0;
            ent_reg      <= '0;
            grp_reg      <= '0;
            row_reg      <= '0;
            prod_vld_reg <= 1'b0;
            prod_sh_reg  <= 1'b0;
            prod_neg_reg <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                box_min_reg[k] <= '0;
                box_max_reg[k] <= '0;
            end
            for (int k = 0; k < NUM_COORD; k++) begin
                mat_reg[k] <= (k % 4 == 0) ? (MAT_W'(1) <<< MAT_FRAC) : '0;
            end
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            step_reg     <= step_next;
            ent_reg      <= ent_next;
            grp_reg      <= grp_next;
            row_reg      <= row_next;
            prod_vld_reg <= prod_vld_next;
            prod_sh_reg  <= prod_sh_next;
            prod_neg_reg <= prod_neg_next;
            if (state_reg == ST_STORE && step_reg < 4'd3) begin
                if (cnt_reg == '0 || in_cur < box_min_reg[axis]) begin
                    box_min_reg[axis] <= in_cur;
                end
                if (cnt_reg == '0 || in_cur > box_max_reg[axis]) begin
                    box_max_reg[axis] <= in_cur;
                end
            end
            if (state_reg == ST_MAT && step_reg == 4'd6) begin
                mat_reg[ent_reg] <= MAT_W'((acc_reg + (ACC_W'(1) <<< 21)) >>> 22);
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (in_acc) begin
            for (int k = 0; k < NUM_COORD; k++) begin
                in_reg[k] <= s_tdata[k*COORD_W +: COORD_W];
            end
            in_flag_reg <= s_tuser;
            in_fin_reg  <= s_tlast;
        end
        if (state_reg == ST_LOAD && step_reg != 4'd0) begin
            pt_reg[step_reg - 4'd1] <= mem_rd_reg;
            if (step_reg == 4'd1) begin
                pt_flag_reg <= flag_rd_reg;
            end
        end
        if (state_reg == ST_CALC && step_reg == 4'd7) begin
            // group 1 is the back handle (flag bit 0), group 2 the fore handle
            if (grp_reg != 2'd0 && !pt_flag_reg[grp_reg[1]]) begin
                res_reg[idx3(grp_reg, row_reg)] <= pt_sel;
            end else begin
                res_reg[idx3(grp_reg, row_reg)] <= sat_coord(fin_val);
            end
        end
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result sides active together");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store size");

    a_set_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (cnt_reg == '0 && s_tready))
        else $error("set not cleared after last point");

    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (cnt_reg != '0 && CNT_W'(idx_reg) < cnt_reg))
        else $error("emitting outside stored points");
`endif

endmodule

// ----- test/rotate_points_about_box_center_tb.sv -----
// ----------------------------------------------------------------------------
// rotate_points_about_box_center_tb
// Self-checking bench for the box-center point rotator. Point sets are sent
// with random gaps and output stalls. A behavioral predictor tracks the store,
// the anchor box and the rotation registers. On each closing request it queues
// the rotated points, and every output request is checked against them.
// ----------------------------------------------------------------------------
module rotate_points_about_box_center_tb
    import rpbc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [TDATA_W-1:0] data;
        logic [1:0]         user;
        logic               last;
    } point_req_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata;
    logic [1:0]           s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    rotate_points_about_box_center u_top (.*);

    // predictor state
    logic signed [CFG_W-1:0] angle_reg [6];
    logic signed [31:0]      pt_coord [MAX_POINTS][NUM_COORD];
    logic [1:0]              pt_flags [MAX_POINTS];
    logic signed [31:0]      box_lo [3];
    logic signed [31:0]      box_hi [3];
    int                      pt_count;
    longint                  rot_m [9];
    point_req_t              rotated_q [$];

    int  n_mismatch;
    bit  no_stall;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint rnd_shift(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic longint tri3(longint a, longint b, longint c);
        return a * b * c;
    endfunction

    function automatic void build_rotation();
        longint cy, sy, cp, sp, cr, sr, one;
        longint t [9];
        cy = angle_reg[CFG_COS_YAW];   sy = angle_reg[CFG_SIN_YAW];
        cp = angle_reg[CFG_COS_PITCH]; sp = angle_reg[CFG_SIN_PITCH];
        cr = angle_reg[CFG_COS_ROLL];  sr = angle_reg[CFG_SIN_ROLL];
        one = Q14_ONE;
        t[0] = tri3(cy, one, cr) + tri3(sy, sp, sr);
        t[1] = -tri3(cy, one, sr) + tri3(sy, sp, cr);
        t[2] = tri3(sy, cp, one);
        t[3] = tri3(cp, sr, one);
        t[4] = tri3(cp, cr, one);
        t[5] = -tri3(sp, one, one);
        t[6] = -tri3(sy, one, cr) + tri3(cy, sp, sr);
        t[7] = tri3(sy, one, sr) + tri3(cy, sp, cr);
        t[8] = tri3(cy, cp, one);
        for (int k = 0; k < 9; k++) rot_m[k] = rnd_shift(t[k], 22);
    endfunction

    function automatic void predict_point(point_req_t r);
        point_req_t o;
        longint     acc;
        longint     ctr2 [3];
        if (pt_count < MAX_POINTS) begin
            for (int k = 0; k < NUM_COORD; k++)
                pt_coord[pt_count][k] = r.data[32*k +: 32];
            pt_flags[pt_count] = r.user;
            for (int k = 0; k < 3; k++) begin
                if (pt_count == 0 || pt_coord[pt_count][k] < box_lo[k])
                    box_lo[k] = pt_coord[pt_count][k];
                if (pt_count == 0 || pt_coord[pt_count][k] > box_hi[k])
                    box_hi[k] = pt_coord[pt_count][k];
            end
            pt_count++;
        end
        if (!r.last) return;
        build_rotation();
        for (int j = 0; j < 3; j++) ctr2[j] = longint'(box_lo[j]) + longint'(box_hi[j]);
        for (int p = 0; p < pt_count; p++) begin
            o.user = pt_flags[p];
            o.last = (p == pt_count - 1);
            for (int i = 0; i < 3; i++) begin
                acc = ctr2[i] <<< MAT_FRAC;
                for (int j = 0; j < 3; j++)
                    acc += rot_m[i*3+j] * (2 * longint'(pt_coord[p][j]) - ctr2[j]);
                o.data[32*i +: 32] = clamp32(rnd_shift(acc, 21));
            end
            for (int h = 0; h < 2; h++) begin
                for (int i = 0; i < 3; i++) begin
                    if (pt_flags[p][h]) begin
                        acc = 0;
                        for (int j = 0; j < 3; j++)
                            acc += rot_m[i*3+j] * longint'(pt_coord[p][3+3*h+j]);
                        o.data[32*(3+3*h+i) +: 32] = clamp32(rnd_shift(acc, MAT_FRAC));
                    end else begin
                        o.data[32*(3+3*h+i) +: 32] = pt_coord[p][3+3*h+i];
                    end
                end
            end
            rotated_q = {rotated_q, o};
        end
        pt_count = 0;
    endfunction

    // output checker
    always @(posedge aclk) begin
        point_req_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (rotated_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected output request %h", m_tdata);
            end else begin
                want = rotated_q.pop_front();
                for (int k = 0; k < NUM_COORD; k++) begin
                    if (m_tdata[32*k +: 32] !== want.data[32*k +: 32]) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("coord %0d: expected %h, got %h", k,
                                     want.data[32*k +: 32], m_tdata[32*k +: 32]);
                    end
                end
                if (m_tuser !== want.user || m_tlast !== want.last) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("flags: expected user %b last %b, got user %b last %b",
                                 want.user, want.last, m_tuser, m_tlast);
                end
            end
        end
    end

    // output backpressure
    always @(posedge aclk) begin
        int hold;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (no_stall) begin
            m_tready <= 1'b1;
        end else begin
            hold = $urandom_range(0, 99);
            m_tready <= (hold >= 30) || (hold < 2 && m_tready);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_stall || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0, 1, 2: return $urandom;
            3: return 32'h80000000;
            4: return 32'h7fffffff;
            5: return 32'h0;
            default: return $urandom_range(0, 32'h000fffff) - 32'h00080000;
        endcase
    endfunction

    task automatic send_point(point_req_t r);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= r.data;
        s_tuser  <= r.user;
        s_tlast  <= r.last;
        do @(posedge aclk); while (!s_tready);
        predict_point(r);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_set(int n);
        point_req_t r;
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < NUM_COORD; k++) r.data[32*k +: 32] = pick_coord();
            r.user = 2'($urandom_range(0, 3));
            r.last = (i == n - 1);
            send_point(r);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_angle(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx <= CFG_SIN_ROLL) angle_reg[idx] = v;
        @(posedge aclk);
    endtask

    task automatic set_angles(logic [CFG_W-1:0] cy, logic [CFG_W-1:0] sy,
                              logic [CFG_W-1:0] cp, logic [CFG_W-1:0] sp,
                              logic [CFG_W-1:0] cr, logic [CFG_W-1:0] sr);
        write_angle(CFG_COS_YAW, cy);
        write_angle(CFG_SIN_YAW, sy);
        write_angle(CFG_COS_PITCH, cp);
        write_angle(CFG_SIN_PITCH, sp);
        write_angle(CFG_COS_ROLL, cr);
        write_angle(CFG_SIN_ROLL, sr);
    endtask

    // identity rotation after reset, extreme coordinates, all flag pairs
    task automatic test_reset_identity();
        point_req_t r;
        no_stall = 1'b1;
        for (int i = 0; i < 4; i++) begin
            r.data = '0;
            for (int k = 0; k < NUM_COORD; k++)
                r.data[32*k +: 32] = (i[0] ^ k[0]) ? 32'h7fffffff : 32'h80000000;
            r.user = i[1:0];
            r.last = (i == 3);
            send_point(r);
        end
        // single-point set: box collapses to the point itself
        r.data = {NUM_COORD{32'h00012345}};
        r.user = 2'b11;
        r.last = 1'b1;
        send_point(r);
        wait_drained();
        no_stall = 1'b0;
    endtask

    // quarter turns, sign flips, out-of-range codes and ignored indexes
    task automatic test_angle_extremes();
        set_angles(16'd0, 16'd16384, 16'd0, -16'sd16384, -16'sd16384, 16'd0);
        send_set(3);
        wait_drained();
        set_angles(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        send_set(4);
        wait_drained();
        write_angle(3'd6, 16'h1234);
        write_angle(3'd7, 16'hffff);
        set_angles(16'd11585, 16'd11585, 16'd11585, -16'sd11585, 16'd11585, 16'd11585);
        send_set(3);
        wait_drained();
    endtask

    // overfull store: points beyond the limit and the closing one are dropped
    task automatic test_store_overflow();
        send_set(MAX_POINTS + 3);
        wait_drained();
        send_set(MAX_POINTS);
        wait_drained();
    endtask

    task automatic test_random_sets();
        int sent;
        int n;
        sent = 0;
        while (sent < 250) begin
            if ($urandom_range(0, 3) == 0) begin
                wait_drained();
                for (int k = 0; k <= CFG_SIN_ROLL; k++)
                    write_angle(CFG_IDX_W'(k), ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                   : 16'($urandom_range(0, 32768) - 16384));
            end
            no_stall = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 15) == 0) begin
                n = $urandom_range(20, 40);
            end else begin
                n = $urandom_range(1, 8);
            end
            send_set(n);
            sent += n;
        end
        no_stall = 1'b0;
    endtask

    initial begin
        n_mismatch = 0;
        no_stall   = 1'b0;
        pt_count   = 0;
        for (int k = 0; k < 3; k++) begin
            box_lo[k] = '0;
            box_hi[k] = '0;
        end
        angle_reg[CFG_COS_YAW]   = Q14_ONE; angle_reg[CFG_SIN_YAW]   = '0;
        angle_reg[CFG_COS_PITCH] = Q14_ONE; angle_reg[CFG_SIN_PITCH] = '0;
        angle_reg[CFG_COS_ROLL]  = Q14_ONE; angle_reg[CFG_SIN_ROLL]  = '0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_reset_identity();
        test_angle_extremes();
        test_store_overflow();
        test_random_sets();
        wait_drained();
        repeat (200) @(posedge aclk);

        if (n_mismatch == 0 && rotated_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
